FILE: design/psa_pkg.sv
// Shared types and constants for the page slot allocator.
`default_nettype none
package psa_pkg;

  localparam int DEF_SLOT_COUNT = 64;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam int ADDR_W  = 64;
  localparam int FRAME_W = 32;
  localparam int USED_W  = 7;

  localparam int SCAN_W     = 8;
  localparam int SCAN_SEL_W = 3;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } add_op_t;

endpackage
`default_nettype wire

FILE: design/page_slot_allocator.sv
// Allocate: scans 8-slot groups in order up to the first group holding a free slot (all groups
//   when the table is full), then forms the slot address if one was found, and registers the result.
// Free, lookup and query: decode on the shared adder, frame read, result.
// One item at a time; the next input is taken the cycle after the result is registered,
//   and a result still stalled at the output holds the next one in the result stage.
// Reset (synchronous): allocated bits, slot count and base address clear at once.
`default_nettype none
module page_slot_allocator
  import psa_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [ADDR_W-1:0]  cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [ADDR_W-1:0]  in_address,
  input  wire logic [FRAME_W-1:0] in_frame_number,
  input  wire logic               in_hint_given,
  input  wire logic               in_release_on_free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_ok,
  output logic      [ADDR_W-1:0]  out_slot_address,
  output logic      [FRAME_W-1:0] out_frame_out,
  output logic                    out_release_frame,
  output logic      [USED_W-1:0]  out_used_slots
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int CHUNKS = (SLOT_COUNT + SCAN_W - 1) / SCAN_W;
  localparam int CCW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADDR,
    S_DEC,
    S_READ,
    S_PUT
  } state_t;

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic                hint_r, hint_nxt;
  logic                relreq_r, relreq_nxt;
  logic [CCW-1:0]      chunk_r, chunk_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   saddr_r, saddr_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [ADDR_W-1:0]   out_saddr_r, out_saddr_nxt;
  logic [FRAME_W-1:0]  out_frame_r, out_frame_nxt;
  logic                out_rel_r, out_rel_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  add_op_t             add_op;
  logic [ADDR_W-1:0]   add_opnd;
  logic [ADDR_W-1:0]   add_sum;
  logic                dec_hit;
  logic [IDX_W-1:0]    dec_idx;
  logic                scan_found;
  logic [IDX_W-1:0]    scan_idx;
  logic                ram_we;
  logic                ram_re;
  logic [FRAME_W-1:0]  ram_rdata;
  logic                hit;
  logic                put_go;

  psa_addr_unit #(
    .SLOT_COUNT (SLOT_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT),
    .IDX_W      (IDX_W)
  ) u_addr (
    .op   (add_op),
    .base (base_r),
    .opnd (add_opnd),
    .sum  (add_sum),
    .hit  (dec_hit),
    .idx  (dec_idx)
  );

  psa_slot_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W),
    .CHUNKS     (CHUNKS),
    .CCW        (CCW)
  ) u_scan (
    .used  (used_r),
    .chunk (chunk_r),
    .found (scan_found),
    .idx   (scan_idx)
  );

  psa_frame_ram #(
    .DEPTH (SLOT_COUNT),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r),
    .wr_data (frame_r),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign add_op   = (state_r == S_DEC) ? OP_SUB : OP_ADD;
  assign add_opnd = (state_r == S_DEC) ? addr_r : (ADDR_W'(idx_r) << PAGE_SHIFT);
  assign hit      = found_r && used_r[idx_r];
  assign put_go   = (state_r == S_PUT) && (!out_valid_r || !out_stall);
  assign ram_we   = put_go && (req_r == REQ_ALLOC) && found_r;
  assign ram_re   = (state_r == S_READ);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    frame_nxt     = frame_r;
    hint_nxt      = hint_r;
    relreq_nxt    = relreq_r;
    chunk_nxt     = chunk_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    saddr_nxt     = saddr_r;
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_saddr_nxt = out_saddr_r;
    out_frame_nxt = out_frame_r;
    out_rel_nxt   = out_rel_r;
    out_used_nxt  = out_used_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = req_t'(in_req_type);
          addr_nxt   = in_address;
          frame_nxt  = in_frame_number;
          hint_nxt   = in_hint_given;
          relreq_nxt = in_release_on_free;
          chunk_nxt  = '0;
          state_nxt  = (req_t'(in_req_type) == REQ_ALLOC) ? S_SCAN : S_DEC;
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          idx_nxt   = scan_idx;
          found_nxt = 1'b1;
          state_nxt = S_ADDR;
        end else if (chunk_r == CCW'(CHUNKS - 1)) begin
          found_nxt = 1'b0;
          state_nxt = S_PUT;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_ADDR: begin
        saddr_nxt = add_sum;
        state_nxt = S_PUT;
      end
      S_DEC: begin
        idx_nxt   = dec_idx;
        found_nxt = dec_hit;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (put_go) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_saddr_nxt = '0;
          out_frame_nxt = '0;
          out_rel_nxt   = 1'b0;
          case (req_r)
            REQ_ALLOC: begin
              if (found_r) begin
                out_ok_nxt      = 1'b1;
                out_saddr_nxt   = saddr_r;
                used_nxt[idx_r] = 1'b1;
                cnt_nxt         = cnt_r + 1'b1;
              end else if (!hint_r) begin
                out_frame_nxt = frame_r;
                out_rel_nxt   = 1'b1;
              end
            end
            REQ_FREE: begin
              out_ok_nxt = hit;
              if (hit) begin
                used_nxt[idx_r] = 1'b0;
                cnt_nxt         = cnt_r - 1'b1;
                if (relreq_r) begin
                  out_frame_nxt = ram_rdata;
                  out_rel_nxt   = 1'b1;
                end
              end
            end
            REQ_LOOKUP: begin
              out_ok_nxt = hit;
              if (hit) begin
                out_frame_nxt = ram_rdata;
              end
            end
            default: begin
              out_ok_nxt = hit;
            end
          endcase
          out_used_nxt = USED_W'(cnt_nxt);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    frame_r     <= frame_nxt;
    hint_r      <= hint_nxt;
    relreq_r    <= relreq_nxt;
    chunk_r     <= chunk_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    saddr_r     <= saddr_nxt;
    out_ok_r    <= out_ok_nxt;
    out_saddr_r <= out_saddr_nxt;
    out_frame_r <= out_frame_nxt;
    out_rel_r   <= out_rel_nxt;
    out_used_r  <= out_used_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_slot_address  = out_saddr_r;
  assign out_frame_out     = out_frame_r;
  assign out_release_frame = out_rel_r;
  assign out_used_slots    = out_used_r;

`ifndef NO_ASSERTIONS
  a_cnt_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == 32'($countones(used_r)))
    else $error("slot count differs from allocated bits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(SLOT_COUNT))
    else $error("slot count above table size");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && req_r == REQ_ALLOC && found_r) |-> !used_r[idx_r])
    else $error("allocate picked a slot already in use");

  a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_PUT))
    else $error("result raised outside the result state");
`endif

endmodule
`default_nettype wire

FILE: design/psa_frame_ram.sv
// Frame number store: one write port, one registered read port.
`default_nettype none
module psa_frame_ram
  import psa_pkg::*;
#(
  parameter int DEPTH = DEF_SLOT_COUNT,
  parameter int IDX_W = $clog2(DEF_SLOT_COUNT)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [FRAME_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output logic      [FRAME_W-1:0] rd_data
);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [FRAME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/psa_addr_unit.sv
// Shared 64-bit adder: slot address generation and address-to-slot decode.
`default_nettype none
module psa_addr_unit
  import psa_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
  parameter int IDX_W      = $clog2(DEF_SLOT_COUNT)
) (
  input  wire add_op_t           op,
  input  wire logic [ADDR_W-1:0] base,
  input  wire logic [ADDR_W-1:0] opnd,
  output logic      [ADDR_W-1:0] sum,
  output logic                   hit,
  output logic      [IDX_W-1:0]  idx
);

  logic [ADDR_W-1:0] a;
  logic [ADDR_W-1:0] b;
  logic [ADDR_W-1:0] page;

  always_comb begin
    a    = (op == OP_SUB) ? opnd : base;
    b    = (op == OP_SUB) ? ~base : opnd;
    sum  = a + b + ADDR_W'(op == OP_SUB);
    page = sum >> PAGE_SHIFT;
    hit  = (opnd != '0) && (page < ADDR_W'(SLOT_COUNT));
    idx  = sum[PAGE_SHIFT +: IDX_W];
  end

endmodule
`default_nettype wire

FILE: design/psa_slot_scan.sv
// First-free search over one group of slot valid bits.
`default_nettype none
module psa_slot_scan
  import psa_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  parameter int IDX_W      = $clog2(DEF_SLOT_COUNT),
  parameter int CHUNKS     = (DEF_SLOT_COUNT + SCAN_W - 1) / SCAN_W,
  parameter int CCW        = 3
) (
  input  wire logic [SLOT_COUNT-1:0] used,
  input  wire logic [CCW-1:0]        chunk,
  output logic                       found,
  output logic      [IDX_W-1:0]      idx
);

  localparam int PAD_N = CHUNKS * SCAN_W;

  logic [PAD_N-1:0]      pad;
  logic [SCAN_W-1:0]     grp;
  logic [SCAN_SEL_W-1:0] off;

  for (genvar g = 0; g < PAD_N; g++) begin : g_pad
    if (g < SLOT_COUNT) begin : g_real
      assign pad[g] = used[g];
    end else begin : g_fill
      assign pad[g] = 1'b1;
    end
  end

  always_comb begin
    grp   = pad[chunk*SCAN_W +: SCAN_W];
    found = ~&grp;
    off   = '0;
    for (int j = SCAN_W - 1; j >= 0; j--) begin
      if (!grp[j]) begin
        off = SCAN_SEL_W'(j);
      end
    end
    idx = IDX_W'({chunk, off});
  end

endmodule
`default_nettype wire
